// ===== rtl/rag_pkg.sv =====
package rag_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int IDX_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_NPROC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NRES = 1'b1;

  localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 5'd16;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_WAIT = 1'b1;

  typedef struct packed {
    logic store;
    logic init;
    logic build_step;
    logic search_step;
  } dp_cmd_t;

  typedef struct packed {
    logic build_done;
    logic search_done;
    logic found;
  } dp_sts_t;

endpackage

// ===== rtl/rag_dp.sv =====
module rag_dp #(
  parameter int MAX_NODES = rag_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [rag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rag_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_req_type,
  input  logic [rag_pkg::IDX_W-1:0]        in_row_index,
  input  logic [rag_pkg::IDX_W-1:0]        in_col_index,
  input  logic                             in_edge_bit,
  input  rag_pkg::dp_cmd_t                 cmd,
  output rag_pkg::dp_sts_t                 sts
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CW = (CNT_W > rag_pkg::CFG_DATA_W) ? CNT_W : rag_pkg::CFG_DATA_W;

  logic [rag_pkg::CFG_DATA_W-1:0] nproc_r;
  logic [rag_pkg::CFG_DATA_W-1:0] nres_r;

  logic [MAX_NODES-1:0] held_r [MAX_NODES];
  logic [MAX_NODES-1:0] waits_r [MAX_NODES];
  logic [MAX_NODES-1:0] adj_r [MAX_NODES];
  logic [NODE_W-1:0]    frame_node_r [MAX_NODES];
  logic [CNT_W-1:0]     frame_cur_r [MAX_NODES];

  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [MAX_NODES-1:0] on_path_r, on_path_nxt;
  logic [CNT_W-1:0]     depth_r, depth_nxt;
  logic [CNT_W-1:0]     root_r, root_nxt;
  logic [CNT_W-1:0]     hop_r;
  logic                 found_r;

  logic [CNT_W-1:0]     pc, rc;
  logic [MAX_NODES-1:0] pmask;
  logic [NODE_W-1:0]    hop_idx, root_idx, top_idx, push_idx, push_node, q_idx;
  logic [NODE_W-1:0]    top_node;
  logic [CNT_W-1:0]     top_cur;
  logic                 inc_en, push_en, hit, done;
  logic                 row_ok, col_ok;
  logic [NODE_W-1:0]    row_idx, col_idx;

  always_comb begin
    if (CW'(nproc_r) > CW'(MAX_NODES)) begin
      pc = CNT_W'(MAX_NODES);
    end else begin
      pc = CNT_W'(nproc_r);
    end
    if (CW'(nres_r) > CW'(MAX_NODES)) begin
      rc = CNT_W'(MAX_NODES);
    end else begin
      rc = CNT_W'(nres_r);
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      pmask[i] = (CNT_W'(i) < pc);
    end
  end

  assign row_ok  = (int'(in_row_index) < MAX_NODES);
  assign col_ok  = (int'(in_col_index) < MAX_NODES);
  assign row_idx = NODE_W'(in_row_index);
  assign col_idx = NODE_W'(in_col_index);

  assign hop_idx  = hop_r[NODE_W-1:0];
  assign root_idx = root_r[NODE_W-1:0];
  assign top_idx  = NODE_W'(depth_r - CNT_W'(1));
  assign top_node = frame_node_r[top_idx];
  assign top_cur  = frame_cur_r[top_idx];
  assign q_idx    = top_cur[NODE_W-1:0];
  assign push_idx = depth_r[NODE_W-1:0];

  always_comb begin
    visited_nxt = visited_r;
    on_path_nxt = on_path_r;
    depth_nxt   = depth_r;
    root_nxt    = root_r;
    inc_en      = 1'b0;
    push_en     = 1'b0;
    push_node   = q_idx;
    hit         = 1'b0;
    done        = 1'b0;
    if (depth_r == '0) begin
      push_node = root_idx;
      if (root_r >= pc) begin
        done = 1'b1;
      end else if (visited_r[root_idx]) begin
        root_nxt = root_r + CNT_W'(1);
      end else begin
        visited_nxt[root_idx] = 1'b1;
        on_path_nxt[root_idx] = 1'b1;
        push_en   = 1'b1;
        depth_nxt = CNT_W'(1);
      end
    end else if (top_cur >= pc) begin
      on_path_nxt[top_node] = 1'b0;
      depth_nxt = depth_r - CNT_W'(1);
    end else begin
      inc_en = 1'b1;
      if (adj_r[top_node][q_idx]) begin
        if (on_path_r[q_idx]) begin
          hit  = 1'b1;
          done = 1'b1;
        end else if (!visited_r[q_idx] && (depth_r < CNT_W'(MAX_NODES))) begin
          visited_nxt[q_idx] = 1'b1;
          on_path_nxt[q_idx] = 1'b1;
          push_en   = 1'b1;
          depth_nxt = depth_r + CNT_W'(1);
        end
      end
    end
  end

  assign sts.build_done  = (hop_r >= rc);
  assign sts.search_done = done;
  assign sts.found       = found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nproc_r <= rag_pkg::COUNT_RESET;
      nres_r  <= rag_pkg::COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rag_pkg::CFG_NPROC: nproc_r <= cfg_data;
        rag_pkg::CFG_NRES:  nres_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        held_r[i]  <= '0;
        waits_r[i] <= '0;
      end
    end else if (cmd.store && row_ok && col_ok) begin
      if (in_req_type == rag_pkg::REQ_WAIT) begin
        waits_r[row_idx][col_idx] <= in_edge_bit;
      end else begin
        held_r[row_idx][col_idx] <= in_edge_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int p = 0; p < MAX_NODES; p++) begin
        adj_r[p] <= '0;
      end
    end else if (cmd.build_step) begin
      for (int p = 0; p < MAX_NODES; p++) begin
        if (pmask[p] && waits_r[p][hop_idx]) begin
          adj_r[p] <= adj_r[p] | (held_r[hop_idx] & pmask);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_step && inc_en) begin
      frame_cur_r[top_idx] <= top_cur + CNT_W'(1);
    end
    if (cmd.search_step && push_en) begin
      frame_node_r[push_idx] <= push_node;
      frame_cur_r[push_idx]  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      on_path_r <= '0;
      depth_r   <= '0;
      root_r    <= '0;
      hop_r     <= '0;
      found_r   <= 1'b0;
    end else if (cmd.init) begin
      visited_r <= '0;
      on_path_r <= '0;
      depth_r   <= '0;
      root_r    <= '0;
      hop_r     <= '0;
      found_r   <= 1'b0;
    end else begin
      if (cmd.build_step) begin
        hop_r <= hop_r + CNT_W'(1);
      end
      if (cmd.search_step) begin
        visited_r <= visited_nxt;
        on_path_r <= on_path_nxt;
        depth_r   <= done ? '0 : depth_nxt;
        root_r    <= root_nxt;
        if (hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rag_ctrl.sv =====
module rag_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_stall,
  output logic              out_valid,
  output logic              out_deadlock,
  input  logic              out_stall,
  output rag_pkg::dp_cmd_t  cmd,
  input  rag_pkg::dp_sts_t  sts
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_BUILD  = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_deadlock_r, out_deadlock_nxt;
  logic   accept, out_free, load;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == ST_DONE) && out_free;

  assign cmd.store       = accept;
  assign cmd.init        = accept && in_last;
  assign cmd.build_step  = (state_r == ST_BUILD) && !sts.build_done;
  assign cmd.search_step = (state_r == ST_SEARCH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept && in_last) state_nxt = ST_BUILD;
      ST_BUILD:  if (sts.build_done) state_nxt = ST_SEARCH;
      ST_SEARCH: if (sts.search_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_deadlock_nxt = out_deadlock_r;
    if (load) begin
      out_valid_nxt    = 1'b1;
      out_deadlock_nxt = sts.found;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_deadlock_r <= out_deadlock_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_deadlock = out_deadlock_r;

endmodule

// ===== rtl/rag_deadlock_cycle_detect.sv =====
// Resource-allocation-graph deadlock detector.
// Input channel (in_valid/in_stall): each beat writes one bit of the
// allocation matrix (in_req_type 0, row = resource, col = process) or the
// request matrix (in_req_type 1, row = process, col = resource).
// A beat with in_last set stores its bit and then searches the wait-for
// graph; out_deadlock comes back as one beat on out_valid/out_stall.
// A beat without in_last leaves the block idle and gives no result.
// A detection beat holds in_stall high through the adjacency build (one
// of the rc resource columns per cycle), then the depth-first search over
// the pc processes (one step per cycle), then the load of the output register;
// pc and rc are the configured counts, saturated at MAX_NODES.
// The output register lets the next beats load while a result waits; a
// new result waits in the done state until the receiver takes the old one.
// cfg_valid/cfg_ready writes the process count (index 0) or the resource
// count (index 1); cfg_ready is always high. Write only while the block is idle.
// Reset clears both matrices, sets both counts to 16 and empties the output.
module rag_deadlock_cycle_detect #(
  parameter int MAX_NODES = rag_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rag_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [rag_pkg::IDX_W-1:0]       in_row_index,
  input  logic [rag_pkg::IDX_W-1:0]       in_col_index,
  input  logic                            in_edge_bit,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_deadlock
);

  rag_pkg::dp_cmd_t cmd;
  rag_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  rag_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last      (in_last),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_deadlock (out_deadlock),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  rag_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req_type  (in_req_type),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_edge_bit  (in_edge_bit),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
